### hdl/pqmm_pkg.sv
// ----------------------------------------------------------------------------
// pqmm_pkg
// types, register codes and arithmetic widths shared by the motor mixer
// ----------------------------------------------------------------------------
package pqmm_pkg;

  localparam int unsigned AngleW  = 16;  // signed q8.8 sample
  localparam int unsigned GainW   = 16;  // unsigned q4.12 gain
  localparam int unsigned MotorW  = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam int unsigned ErrW    = AngleW + 1;        // q9.8
  localparam int unsigned DerW    = ErrW + 1;          // q10.8
  localparam int unsigned PropW   = ErrW + GainW + 1;  // signed x zero-extended gain
  localparam int unsigned DervW   = DerW + GainW + 1;
  localparam int unsigned TermW   = DervW + 1;
  localparam int unsigned SumW    = TermW + 2;
  localparam int unsigned FracW   = 20;                // q.20 after gain product

  localparam logic [CfgIdxW-1:0] RegAltKp = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegAltKd = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegAttKp = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegAttKd = CfgIdxW'(3);

  localparam logic [GainW-1:0] AltKpReset = GainW'(3277);
  localparam logic [GainW-1:0] AltKdReset = GainW'(1229);
  localparam logic [GainW-1:0] AttKpReset = GainW'(4915);
  localparam logic [GainW-1:0] AttKdReset = GainW'(2048);

  typedef struct packed {
    logic signed [AngleW-1:0] target_altitude;
    logic signed [AngleW-1:0] current_altitude;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic [MotorW-1:0] motor_front_a;
    logic [MotorW-1:0] motor_front_b;
    logic [MotorW-1:0] motor_rear_a;
    logic [MotorW-1:0] motor_rear_b;
  } out_item_t;

  // error and derivative of one axis
  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [DerW-1:0] der;
  } axis_err_t;

  // proportional and derivative products of one axis
  typedef struct packed {
    logic signed [PropW-1:0] prop;
    logic signed [DervW-1:0] derv;
  } axis_prod_t;

  // floor to integer part and clamp to the motor range
  function automatic logic [MotorW-1:0] sat_motor(logic signed [SumW-1:0] sum);
    logic [MotorW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (|sum[SumW-2:FracW+MotorW]) begin
      res = '1;
    end else begin
      res = sum[FracW+MotorW-1:FracW];
    end
    return res;
  endfunction

endpackage

### hdl/pqmm_if.sv
// ----------------------------------------------------------------------------
// pqmm channel interfaces
// valid/ready channels for samples, motor drives and gain writes
// ----------------------------------------------------------------------------
interface pqmm_in_if;
  logic                valid;
  logic                ready;
  pqmm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pqmm_out_if;
  logic                valid;
  logic                ready;
  pqmm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pqmm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pqmm_pkg::CfgIdxW-1:0]      addr;
  logic [pqmm_pkg::GainW-1:0]        wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

### hdl/pd_quad_motor_mixer.sv
// ----------------------------------------------------------------------------
// pd_quad_motor_mixer: pd altitude/attitude control with x-pattern motor mix
// sample beat to motor beat through the registered error, product and mix stages
// one sample per cycle unless out_o stalls; six gain multipliers set the mid stage
// reset clears the pipeline, the previous errors and loads the default gains
// ----------------------------------------------------------------------------
module pd_quad_motor_mixer (
  input  logic       clk_i,
  input  logic       rst_ni,
  pqmm_in_if.sink    in_i,
  pqmm_out_if.source out_o,
  pqmm_cfg_if.sink   cfg_i
);
  import pqmm_pkg::*;

  logic [GainW-1:0] alt_kp_q, alt_kd_q, att_kp_q, att_kd_q;

  logic signed [ErrW-1:0] alt_last_q, pit_last_q, rol_last_q;

  logic      a_valid_q, b_valid_q, out_valid_q;
  axis_err_t a_alt_q, a_pit_q, a_rol_q;
  axis_prod_t b_alt_q, b_pit_q, b_rol_q;
  out_item_t out_q;

  logic out_adv, b_adv, a_adv, in_fire;

  axis_err_t  alt_d, pit_d, rol_d;
  axis_prod_t palt_d, ppit_d, prol_d;
  out_item_t  out_d;

  logic signed [TermW-1:0] t_alt, t_pit, t_rol;
  logic signed [SumW-1:0]  s_fa, s_fb, s_ra, s_rb;

  // stall chain: a stage moves on when the next one is empty or moving
  assign out_adv = !out_valid_q || out_o.ready;
  assign b_adv   = !b_valid_q || out_adv;
  assign a_adv   = !a_valid_q || b_adv;
  assign in_i.ready = a_adv;
  assign in_fire = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // error stage
  always_comb begin
    alt_d.err = ErrW'(in_i.data.target_altitude) - ErrW'(in_i.data.current_altitude);
    pit_d.err = ErrW'(0) - ErrW'(in_i.data.pitch_angle);
    rol_d.err = ErrW'(0) - ErrW'(in_i.data.roll_angle);
    alt_d.der = DerW'(alt_d.err) - DerW'(alt_last_q);
    pit_d.der = DerW'(pit_d.err) - DerW'(pit_last_q);
    rol_d.der = DerW'(rol_d.err) - DerW'(rol_last_q);
  end

  // product stage
  always_comb begin
    palt_d.prop = PropW'(a_alt_q.err) * PropW'($signed({1'b0, alt_kp_q}));
    palt_d.derv = DervW'(a_alt_q.der) * DervW'($signed({1'b0, alt_kd_q}));
    ppit_d.prop = PropW'(a_pit_q.err) * PropW'($signed({1'b0, att_kp_q}));
    ppit_d.derv = DervW'(a_pit_q.der) * DervW'($signed({1'b0, att_kd_q}));
    prol_d.prop = PropW'(a_rol_q.err) * PropW'($signed({1'b0, att_kp_q}));
    prol_d.derv = DervW'(a_rol_q.der) * DervW'($signed({1'b0, att_kd_q}));
  end

  // mix stage
  always_comb begin
    t_alt = TermW'(b_alt_q.prop) + TermW'(b_alt_q.derv);
    t_pit = TermW'(b_pit_q.prop) + TermW'(b_pit_q.derv);
    t_rol = TermW'(b_rol_q.prop) + TermW'(b_rol_q.derv);
    s_fa  = SumW'(t_alt) - SumW'(t_pit) + SumW'(t_rol);
    s_fb  = SumW'(t_alt) + SumW'(t_pit) - SumW'(t_rol);
    s_ra  = SumW'(t_alt) + SumW'(t_pit) + SumW'(t_rol);
    s_rb  = SumW'(t_alt) - SumW'(t_pit) - SumW'(t_rol);
    out_d.motor_front_a = sat_motor(s_fa);
    out_d.motor_front_b = sat_motor(s_fb);
    out_d.motor_rear_a  = sat_motor(s_ra);
    out_d.motor_rear_b  = sat_motor(s_rb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_kp_q    <= AltKpReset;
      alt_kd_q    <= AltKdReset;
      att_kp_q    <= AttKpReset;
      att_kd_q    <= AttKdReset;
      alt_last_q  <= '0;
      pit_last_q  <= '0;
      rol_last_q  <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.addr)
          RegAltKp: alt_kp_q <= cfg_i.wdata;
          RegAltKd: alt_kd_q <= cfg_i.wdata;
          RegAttKp: att_kp_q <= cfg_i.wdata;
          RegAttKd: att_kd_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        alt_last_q <= alt_d.err;
        pit_last_q <= pit_d.err;
        rol_last_q <= rol_d.err;
      end
      if (a_adv) begin
        a_valid_q <= in_i.valid;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_alt_q <= alt_d;
      a_pit_q <= pit_d;
      a_rol_q <= rol_d;
    end
    if (b_adv && a_valid_q) begin
      b_alt_q <= palt_d;
      b_pit_q <= ppit_d;
      b_rol_q <= prol_d;
    end
    if (out_adv && b_valid_q) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_last_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> a_valid_q && alt_last_q == a_alt_q.err
      && pit_last_q == a_pit_q.err && rol_last_q == a_rol_q.err)
    else $error("previous error store does not match the item in the error stage");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_adv |=> a_valid_q && $stable(a_alt_q) && $stable(a_pit_q)
      && $stable(a_rol_q))
    else $error("error stage changed while stalled");

  b_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !out_adv |=> b_valid_q && $stable(b_alt_q) && $stable(b_pit_q)
      && $stable(b_rol_q))
    else $error("product stage changed while stalled");

  b_fill_from_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv && a_valid_q |=> b_valid_q)
    else $error("item lost between error and product stage");
`endif

endmodule
